// ----- rtl/tbrea_pkg.sv -----
// ----------------------------------------------------------------------------
// tbrea_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the three-band rms energy analyzer.
// ----------------------------------------------------------------------------
package tbrea_pkg;

  localparam int DEF_MAX_BLOCK   = 4096;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 32;
  localparam int SMOOTH_W   = 17;
  localparam int SMOOTH_RST = 6554;

  localparam int MA_W     = 34;
  localparam int ACC_W    = 64;
  localparam int SUM_W    = 58;
  localparam int EMA_W    = 40;
  localparam int OUT_W    = 23;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SREM_W   = ROOT_W + 3;
  localparam int DIFF_W   = EMA_W + 1;
  localparam int EP_W     = SMOOTH_W + 1 + DIFF_W;
  localparam int STEP_W   = $clog2(SUM_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_A1  = 3'd0,
    REG_LOW_A2  = 3'd1,
    REG_HIGH_A1 = 3'd2,
    REG_HIGH_A2 = 3'd3,
    REG_SMOOTH  = 3'd4
  } cfg_reg_e;

  // filter slots, processed in this order
  localparam logic [1:0] FILT_LP_LOW  = 2'd0;
  localparam logic [1:0] FILT_HP_LOW  = 2'd1;
  localparam logic [1:0] FILT_LP_HIGH = 2'd2;
  localparam logic [1:0] FILT_HP_HIGH = 2'd3;

  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // biquad micro steps: products on 0..4, accumulate on 1..5, round on 6
  localparam logic [2:0] TERM_X0   = 3'd0;
  localparam logic [2:0] TERM_X1   = 3'd1;
  localparam logic [2:0] TERM_X2   = 3'd2;
  localparam logic [2:0] TERM_Y1   = 3'd3;
  localparam logic [2:0] TERM_Y2   = 3'd4;
  localparam logic [2:0] TERM_LAST = 3'd5;
  localparam logic [2:0] TERM_FIN  = 3'd6;

  typedef struct packed {
    logic       load;
    logic       mac;
    logic       sq_mul;
    logic       sq_add;
    logic       div_init;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       ema_diff;
    logic       ema_mul;
    logic       ema_upd;
    logic       out_load;
    logic [1:0] filt;
    logic [2:0] term;
    logic [1:0] band;
  } dp_cmd_t;

  typedef struct packed {
    logic block_end;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/tbrea_datapath.sv -----
// ----------------------------------------------------------------------------
// tbrea_datapath
// Configuration registers, biquad history, shared multiply-accumulate,
// square sums, radix-2 divider, bit-pair square root, smoothing and output
// register.
// ----------------------------------------------------------------------------
module tbrea_datapath import tbrea_pkg::*; #(
  parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_W-1:0]       low_energy_o,
  output logic [OUT_W-1:0]       mid_energy_o,
  output logic [OUT_W-1:0]       high_energy_o,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int PROD_W = MA_W + SAMPLE_BITS;

  localparam logic signed [MA_W-1:0]  ONE_Q30 = MA_W'(64'sd1 <<< 30);
  localparam logic signed [ACC_W-1:0] RND_Q29 = 64'sd1 <<< 29;
  localparam logic signed [ACC_W-1:0] Y_MAX   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] Y_MIN   = -Y_MAX - 64'sd1;
  localparam logic [ACC_W-1:0]        SUM_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam logic [OUT_W-1:0]        RMS_MAX = '1;
  localparam logic [EMA_W-1:0]        EMA_MAX = {RMS_MAX, 16'd0};
  localparam logic signed [EP_W:0]    RND_16  = (EP_W + 1)'(32768);

  logic signed [COEF_W-1:0]      la1_q, la2_q, ha1_q, ha2_q;
  logic [SMOOTH_W-1:0]           smc_q;
  logic signed [SAMPLE_BITS-1:0] hist_q [4][4];
  logic [SUM_W-1:0]              sum_q [3];
  logic [EMA_W-1:0]              ema_q [3];
  logic [CNT_W-1:0]              cnt_q;
  logic                          end_q;
  logic                          out_valid_q;
  logic [OUT_W-1:0]              out_q [3];

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic [SUM_W-1:0]              quo_q;
  logic [CNT_W-1:0]              drem_q;
  logic [SREM_W-1:0]             srem_q;
  logic [ROOT_W-1:0]             root_q;
  logic signed [DIFF_W-1:0]      diff_q;
  logic signed [EP_W-1:0]        eprod_q;

  logic                          lp;
  logic signed [COEF_W-1:0]      a1, a2;
  logic signed [MA_W-1:0]        a1x, a2x, bsum, b0, b1, ma;
  logic signed [SAMPLE_BITS-1:0] xin, mb, band_y, y_sat;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [ACC_W-1:0]       prod64, rnd, ysh;
  logic [ACC_W-1:0]              tot;
  logic [SUM_W-1:0]              sum_new;
  logic [CNT_W:0]                cnt_inc, r2;
  logic                          dge;
  logic [SREM_W-1:0]             rtmp, trial;
  logic                          sge;
  logic [OUT_W-1:0]              rms;
  logic signed [EP_W:0]          ep_r, et, e_new;
  logic [EMA_W-1:0]              e_clamp;
  logic [EMA_W:0]                o_tmp [3];

  // coefficient selection
  always_comb begin
    lp   = (cmd_i.filt == FILT_LP_LOW) || (cmd_i.filt == FILT_LP_HIGH);
    a1   = cmd_i.filt[1] ? ha1_q : la1_q;
    a2   = cmd_i.filt[1] ? ha2_q : la2_q;
    a1x  = MA_W'(a1);
    a2x  = MA_W'(a2);
    bsum = ONE_Q30 + (lp ? a1x : -a1x) + a2x;
    b0   = bsum >>> 2;
    b1   = lp ? (b0 <<< 1) : -(b0 <<< 1);
    xin  = (cmd_i.filt == FILT_LP_HIGH) ? hist_q[FILT_HP_LOW][2] : x_q;
  end

  always_comb begin
    case (cmd_i.band)
      BAND_LOW: band_y = hist_q[FILT_LP_LOW][2];
      BAND_MID: band_y = hist_q[FILT_LP_HIGH][2];
      default:  band_y = hist_q[FILT_HP_HIGH][2];
    endcase
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.sq_mul) begin
      ma = MA_W'(band_y);
      mb = band_y;
    end else begin
      case (cmd_i.term)
        TERM_X0: begin ma = b0;  mb = xin;                   end
        TERM_X1: begin ma = b1;  mb = hist_q[cmd_i.filt][0]; end
        TERM_X2: begin ma = b0;  mb = hist_q[cmd_i.filt][1]; end
        TERM_Y1: begin ma = a1x; mb = hist_q[cmd_i.filt][2]; end
        TERM_Y2: begin ma = a2x; mb = hist_q[cmd_i.filt][3]; end
        default: begin ma = '0;  mb = '0;                    end
      endcase
    end
    prod_d = PROD_W'(ma) * PROD_W'(mb);
  end

  always_comb begin
    prod64 = ACC_W'(prod_q);
    rnd    = acc_q + RND_Q29;
    ysh    = rnd >>> 30;
    if (ysh > Y_MAX) begin
      y_sat = SAMPLE_BITS'(Y_MAX);
    end else if (ysh < Y_MIN) begin
      y_sat = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_sat = SAMPLE_BITS'(ysh);
    end
    tot     = ACC_W'(sum_q[cmd_i.band]) + prod64;
    sum_new = (tot > SUM_MAX) ? SUM_W'(SUM_MAX) : tot[SUM_W-1:0];
    cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(1);
  end

  // divider and square root steps
  always_comb begin
    r2    = {drem_q, quo_q[SUM_W-1]};
    dge   = r2 >= {1'b0, cnt_q};
    rtmp  = {srem_q[SREM_W-3:0], quo_q[SUM_W-1 -: 2]};
    trial = SREM_W'({root_q, 2'b01});
    sge   = rtmp >= trial;
    rms   = (root_q > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_q[OUT_W-1:0];
  end

  // smoothing update
  always_comb begin
    ep_r  = (EP_W + 1)'(eprod_q) + RND_16;
    et    = ep_r >>> 16;
    e_new = (EP_W + 1)'($signed({1'b0, ema_q[cmd_i.band]})) + et;
    if (e_new < 0) begin
      e_clamp = '0;
    end else if (e_new > (EP_W + 1)'($signed({1'b0, EMA_MAX}))) begin
      e_clamp = EMA_MAX;
    end else begin
      e_clamp = EMA_W'(e_new);
    end
    for (int b = 0; b < 3; b++) begin
      o_tmp[b] = {1'b0, ema_q[b]} + (EMA_W + 1)'(32768);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la1_q       <= '0;
      la2_q       <= '0;
      ha1_q       <= '0;
      ha2_q       <= '0;
      smc_q       <= SMOOTH_W'(SMOOTH_RST);
      for (int f = 0; f < 4; f++) begin
        for (int k = 0; k < 4; k++) begin
          hist_q[f][k] <= '0;
        end
      end
      for (int b = 0; b < 3; b++) begin
        sum_q[b] <= '0;
        ema_q[b] <= '0;
      end
      cnt_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LOW_A1:  la1_q <= cfg_data_i;
          REG_LOW_A2:  la2_q <= cfg_data_i;
          REG_HIGH_A1: ha1_q <= cfg_data_i;
          REG_HIGH_A2: ha2_q <= cfg_data_i;
          REG_SMOOTH:  smc_q <= cfg_data_i[SMOOTH_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cnt_q <= cnt_inc[CNT_W-1:0];
        end_q <= last_i || (cnt_inc >= (CNT_W + 1)'(MAX_BLOCK));
      end
      if (cmd_i.mac && (cmd_i.term == TERM_FIN)) begin
        hist_q[cmd_i.filt][1] <= hist_q[cmd_i.filt][0];
        hist_q[cmd_i.filt][0] <= xin;
        hist_q[cmd_i.filt][3] <= hist_q[cmd_i.filt][2];
        hist_q[cmd_i.filt][2] <= y_sat;
      end
      if (cmd_i.sq_add) begin
        sum_q[cmd_i.band] <= sum_new;
      end
      if (cmd_i.ema_upd) begin
        ema_q[cmd_i.band] <= e_clamp;
        sum_q[cmd_i.band] <= '0;
        if (cmd_i.band == BAND_HIGH) begin
          cnt_q <= '0;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.mac || cmd_i.sq_mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mac) begin
      if (cmd_i.term == TERM_X1) begin
        acc_q <= prod64;
      end else if ((cmd_i.term == TERM_X2) || (cmd_i.term == TERM_Y1)) begin
        acc_q <= acc_q + prod64;
      end else if ((cmd_i.term == TERM_Y2) || (cmd_i.term == TERM_LAST)) begin
        acc_q <= acc_q - prod64;
      end
    end
    if (cmd_i.div_init) begin
      quo_q  <= sum_q[cmd_i.band];
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SUM_W-2:0], dge};
      drem_q <= dge ? CNT_W'(r2 - {1'b0, cnt_q}) : CNT_W'(r2);
    end else if (cmd_i.sqrt_step) begin
      quo_q  <= {quo_q[SUM_W-3:0], 2'b00};
      srem_q <= sge ? (rtmp - trial) : rtmp;
      root_q <= {root_q[ROOT_W-2:0], sge};
    end
    if (cmd_i.sqrt_init) begin
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.ema_diff) begin
      diff_q <= $signed({2'b00, rms, 16'd0}) - $signed({1'b0, ema_q[cmd_i.band]});
    end
    if (cmd_i.ema_mul) begin
      eprod_q <= EP_W'($signed({1'b0, smc_q})) * EP_W'(diff_q);
    end
    if (cmd_i.out_load) begin
      for (int b = 0; b < 3; b++) begin
        out_q[b] <= o_tmp[b][16 +: OUT_W];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign low_energy_o    = out_q[BAND_LOW];
  assign mid_energy_o    = out_q[BAND_MID];
  assign high_energy_o   = out_q[BAND_HIGH];
  assign sts_o.block_end = end_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (CNT_W + 1)'(MAX_BLOCK))
    else $error("sample count beyond block limit");

  a_ema_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ema_q[0] <= EMA_MAX) && (ema_q[1] <= EMA_MAX) && (ema_q[2] <= EMA_MAX))
    else $error("smoothed energy out of range");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q != '0))
    else $error("divide by empty block");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites pending transfer");

endmodule

// ----- rtl/tbrea_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbrea_ctrl
// Sequencer: per sample four biquads and three square sums, and at block end
// a divide, root and smoothing pass per band before the result transfer.
// ----------------------------------------------------------------------------
module tbrea_ctrl import tbrea_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT,
    S_SQ,
    S_DINIT,
    S_DIV,
    S_SINIT,
    S_SQRT,
    S_EDIFF,
    S_EMUL,
    S_EUPD,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [1:0]       filt_q;
  logic [2:0]       term_q;
  logic [1:0]       band_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      filt_q  <= '0;
      term_q  <= '0;
      band_q  <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_FILT;
            filt_q  <= FILT_LP_LOW;
            term_q  <= TERM_X0;
          end
        end
        S_FILT: begin
          if (term_q == TERM_FIN) begin
            term_q <= TERM_X0;
            if (filt_q == FILT_HP_HIGH) begin
              state_q <= S_SQ;
              band_q  <= BAND_LOW;
            end else begin
              filt_q <= filt_q + 2'd1;
            end
          end else begin
            term_q <= term_q + 3'd1;
          end
        end
        S_SQ: begin
          term_q <= {2'b00, !term_q[0]};
          if (term_q[0]) begin
            if (band_q == BAND_HIGH) begin
              band_q  <= BAND_LOW;
              state_q <= sts_i.block_end ? S_DINIT : S_IDLE;
            end else begin
              band_q <= band_q + 2'd1;
            end
          end
        end
        S_DINIT: begin
          state_q <= S_DIV;
          step_q  <= '0;
        end
        S_DIV: begin
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= S_SINIT;
          end
          step_q <= step_q + STEP_W'(1);
        end
        S_SINIT: begin
          state_q <= S_SQRT;
          step_q  <= '0;
        end
        S_SQRT: begin
          if (step_q == STEP_W'(ROOT_W - 1)) begin
            state_q <= S_EDIFF;
          end
          step_q <= step_q + STEP_W'(1);
        end
        S_EDIFF: state_q <= S_EMUL;
        S_EMUL:  state_q <= S_EUPD;
        S_EUPD: begin
          if (band_q == BAND_HIGH) begin
            state_q <= S_OUT;
          end else begin
            band_q  <= band_q + 2'd1;
            state_q <= S_DINIT;
          end
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.filt      = filt_q;
    cmd_o.term      = term_q;
    cmd_o.band      = band_q;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mac       = (state_q == S_FILT);
    cmd_o.sq_mul    = (state_q == S_SQ) && !term_q[0];
    cmd_o.sq_add    = (state_q == S_SQ) && term_q[0];
    cmd_o.div_init  = (state_q == S_DINIT);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.sqrt_init = (state_q == S_SINIT);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.ema_diff  = (state_q == S_EDIFF);
    cmd_o.ema_mul   = (state_q == S_EMUL);
    cmd_o.ema_upd   = (state_q == S_EUPD);
    cmd_o.out_load  = (state_q == S_OUT) && sts_i.out_free;
  end

endmodule

// ----- rtl/three_band_rms_energy_analyzer.sv -----
// ----------------------------------------------------------------------------
// three_band_rms_energy_analyzer
// Biquad three-band splitter with per-block rms and smoothed band energies.
// ----------------------------------------------------------------------------
// samples enter on the in channel (valid/ready) with a last flag that closes
// the analysis block; a block also closes after MAX_BLOCK samples
// each sample passes one shared multiplier, which runs the five products
// of each of the four biquads and the three band squares; in_ready is
// high only while the sequencer is idle
// at block end each band runs a 58-step divider, a 29-step root and
// three smoothing steps before the three energies appear on the out
// channel in one transfer
// the output register holds the result while the receiver stalls; new
// samples are taken meanwhile, but the next block end waits for the
// pending transfer to complete
// the cfg port writes coefficients at once with no handshake; write only
// while the block is idle
// reset clears filter history, sums, count and averages, and loads the
// coefficient reset values
// ----------------------------------------------------------------------------
module three_band_rms_energy_analyzer import tbrea_pkg::*; #(
  parameter int MAX_BLOCK   = DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_W-1:0]       low_energy_o,
  output logic [OUT_W-1:0]       mid_energy_o,
  output logic [OUT_W-1:0]       high_energy_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tbrea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbrea_datapath #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .low_energy_o  (low_energy_o),
    .mid_energy_o  (mid_energy_o),
    .high_energy_o (high_energy_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
